[rtl/ptrf_pkg.sv]
// shared types, codes and constants of the response framer
package ptrf_pkg;

  localparam int BUFFER_DEPTH = 256;
  localparam int CNT_W = $clog2(BUFFER_DEPTH);
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] PROMPT_CHAR = 8'h3E;
  localparam logic [2:0] MATCH_LEN = 3'd5;
  localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

  typedef enum logic [2:0] {
    CMD_BEGIN = 3'd0,
    CMD_DATA  = 3'd1,
    CMD_TICK  = 3'd2,
    CMD_ABORT = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_BUSY     = 2'd1,
    ST_IDLE     = 2'd2,
    ST_DROPPED  = 2'd3
  } status_t;

  // first member lands in the highest bits
  typedef struct packed {
    logic [7:0] read_byte;
    logic [7:0] tag_out;
    logic [7:0] response_len;
    logic       finished_ok;
    logic       finished;
    logic       timed_out;
    logic       busy_res;
    status_t    status;
  } res_t;

  // characters of "ERROR"
  function automatic logic [7:0] err_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h45;
      3'd1:    c = 8'h52;
      3'd2:    c = 8'h52;
      3'd3:    c = 8'h4F;
      3'd4:    c = 8'h52;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[rtl/ptrf_ram.sv]
// generic single-write, single-read ram with registered read data
module ptrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

[rtl/ptrf_front.sv]
// front part: transaction state, reply buffer, error matcher and result staging
module ptrf_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wen,
  input  logic [31:0]                 cfg_wdata,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic [2:0]                  cmd,
  input  logic [7:0]                  command_tag,
  input  logic [7:0]                  data_byte,
  input  logic                        last_in_chunk,
  input  logic [7:0]                  read_index,
  input  logic [ptrf_pkg::QCNT_W-1:0] q_count,
  output logic                        push,
  output ptrf_pkg::res_t              push_res
);

  localparam int CW = ptrf_pkg::CNT_W;

  logic          busy_r, busy_nxt;
  logic [7:0]    tag_r, tag_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [31:0]   elapsed_r, elapsed_nxt;
  logic          prompt_r, prompt_nxt;
  logic [2:0]    mpos_r, mpos_nxt;
  logic          seen_r, seen_nxt;
  logic [31:0]   timeout_r;

  logic           stage_v_r;
  logic           stage_rd_r, rd_hit;
  ptrf_pkg::res_t stage_res_r, res;

  logic       accept;
  logic       ram_we;
  logic [7:0] ram_rdata_r;
  logic       full;
  logic       pr;
  logic [2:0] mp;
  ptrf_pkg::status_t status;
  logic       fin, fin_ok;

  // room for the staged request and a new one
  assign req_ready = stage_v_r ? (q_count <= ptrf_pkg::QCNT_W'(ptrf_pkg::QDEPTH - 2))
                               : (q_count <= ptrf_pkg::QCNT_W'(ptrf_pkg::QDEPTH - 1));
  assign accept = req_valid & req_ready;
  assign full = (count_r == CW'(ptrf_pkg::BUFFER_DEPTH - 1));

  always_comb begin
    busy_nxt    = busy_r;
    tag_nxt     = tag_r;
    count_nxt   = count_r;
    elapsed_nxt = elapsed_r;
    prompt_nxt  = prompt_r;
    mpos_nxt    = mpos_r;
    seen_nxt    = seen_r;
    status      = ptrf_pkg::ST_ACCEPTED;
    fin         = 1'b0;
    fin_ok      = 1'b0;
    ram_we      = 1'b0;
    rd_hit      = 1'b0;
    pr          = 1'b0;
    mp          = 3'd0;
    unique case (ptrf_pkg::cmd_t'(cmd))
      ptrf_pkg::CMD_BEGIN: begin
        if (busy_r) begin
          status = ptrf_pkg::ST_BUSY;
        end else begin
          busy_nxt    = 1'b1;
          tag_nxt     = command_tag;
          count_nxt   = '0;
          elapsed_nxt = '0;
          prompt_nxt  = 1'b0;
          mpos_nxt    = 3'd0;
          seen_nxt    = 1'b0;
        end
      end
      ptrf_pkg::CMD_DATA: begin
        if (!busy_r) begin
          status = ptrf_pkg::ST_IDLE;
        end else begin
          if (!full) begin
            ram_we    = 1'b1;
            count_nxt = count_r + CW'(1);
            if (!seen_r) begin
              if (data_byte == ptrf_pkg::err_char(mpos_r)) begin
                mp = mpos_r + 3'd1;
              end else begin
                mp = (data_byte == ptrf_pkg::err_char(3'd0)) ? 3'd1 : 3'd0;
              end
              if (mp == ptrf_pkg::MATCH_LEN) begin
                seen_nxt = 1'b1;
                mpos_nxt = 3'd0;
              end else begin
                mpos_nxt = mp;
              end
            end
          end else begin
            status = ptrf_pkg::ST_DROPPED;
          end
          pr = prompt_r | (data_byte == ptrf_pkg::PROMPT_CHAR);
          prompt_nxt = pr;
          if (last_in_chunk) begin
            if (pr || seen_nxt) begin
              busy_nxt = 1'b0;
              fin      = 1'b1;
              fin_ok   = 1'b1;
            end
            prompt_nxt = 1'b0;
          end
        end
      end
      ptrf_pkg::CMD_TICK: begin
        if (!busy_r) begin
          status = ptrf_pkg::ST_IDLE;
        end else if (elapsed_r != 32'hFFFF_FFFF) begin
          elapsed_nxt = elapsed_r + 32'd1;
        end
      end
      ptrf_pkg::CMD_ABORT: begin
        if (!busy_r) begin
          status = ptrf_pkg::ST_IDLE;
        end else begin
          busy_nxt   = 1'b0;
          prompt_nxt = 1'b0;
          fin        = 1'b1;
        end
      end
      ptrf_pkg::CMD_READ: begin
        rd_hit = (32'(read_index) < 32'(count_r));
      end
      default: begin
        status = ptrf_pkg::ST_IDLE;
      end
    endcase

    res.status       = status;
    res.busy_res     = busy_nxt;
    res.timed_out    = busy_nxt & (elapsed_nxt >= timeout_r);
    res.finished     = fin;
    res.finished_ok  = fin_ok;
    res.response_len = 8'(count_nxt);
    res.tag_out      = tag_nxt;
    res.read_byte    = 8'd0;
  end

  ptrf_ram #(
    .WIDTH(8),
    .DEPTH(ptrf_pkg::BUFFER_DEPTH)
  ) u_buf (
    .clk    (clk),
    .we     (accept & ram_we),
    .waddr  (count_r),
    .wdata  (data_byte),
    .re     (accept & rd_hit),
    .raddr  (CW'(read_index)),
    .rdata_r(ram_rdata_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      tag_r     <= 8'd0;
      count_r   <= '0;
      elapsed_r <= 32'd0;
      prompt_r  <= 1'b0;
      mpos_r    <= 3'd0;
      seen_r    <= 1'b0;
      timeout_r <= ptrf_pkg::TIMEOUT_RESET;
      stage_v_r <= 1'b0;
    end else begin
      if (cfg_wen) begin
        timeout_r <= cfg_wdata;
      end
      stage_v_r <= accept;
      if (accept) begin
        busy_r    <= busy_nxt;
        tag_r     <= tag_nxt;
        count_r   <= count_nxt;
        elapsed_r <= elapsed_nxt;
        prompt_r  <= prompt_nxt;
        mpos_r    <= mpos_nxt;
        seen_r    <= seen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_res_r <= res;
      stage_rd_r  <= rd_hit;
    end
  end

  // buffer read data arrives in the cycle after the request is taken, together with the staged result
  always_comb begin
    push_res = stage_res_r;
    push_res.read_byte = stage_rd_r ? ram_rdata_r : 8'd0;
  end
  assign push = stage_v_r;

endmodule

[rtl/ptrf_queue.sv]
// back part: small result queue that drives the output channel
module ptrf_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  ptrf_pkg::res_t              push_res,
  output logic [ptrf_pkg::QCNT_W-1:0] q_count,
  output logic                        out_valid,
  input  logic                        out_ready,
  output ptrf_pkg::res_t              out_res
);

  localparam int PW = ptrf_pkg::QPTR_W;
  localparam int NW = ptrf_pkg::QCNT_W;

  ptrf_pkg::res_t  mem_r [ptrf_pkg::QDEPTH];
  logic [PW-1:0]   wr_r, rd_r;
  logic [NW-1:0]   cnt_r;
  logic            pop;

  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rd_r];
  assign q_count   = cnt_r;
  assign pop       = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PW'(ptrf_pkg::QDEPTH - 1)) ? '0 : wr_r + PW'(1);
      end
      if (pop) begin
        rd_r <= (rd_r == PW'(ptrf_pkg::QDEPTH - 1)) ? '0 : rd_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + NW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_res;
    end
  end

endmodule

[rtl/prompt_terminated_response_framer.sv]
// Framer for one command reply at a time: every request returns one result.
// A request is taken every clock cycle while the result queue has room; its
// result passes a staging register, which waits out the registered read of
// the reply buffer memory, and then a four-entry result queue before it is
// offered on the output; the queue lets the output stall without stopping
// the input until it fills. Begin opens a transaction, data bytes are stored
// until the buffer holds its depth minus one, a chunk that held a prompt or a
// reply that contained ERROR closes it at the chunk's last byte, abort closes
// it as failed, ticks count toward the timeout written on the cfg port, and
// read returns a stored byte.
module prompt_terminated_response_framer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wen,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] command_tag, [15:8] data_byte, [23:16] read_index
  input  logic [23:0] in_tdata,
  // [2:0] cmd
  input  logic [2:0]  in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] status, [2] busy_res, [3] timed_out, [4] finished, [5] finished_ok,
  // [13:6] response_len, [21:14] tag_out, [29:22] read_byte
  output logic [31:0] out_tdata
);

  logic                        push;
  ptrf_pkg::res_t              push_res;
  ptrf_pkg::res_t              out_res;
  logic [ptrf_pkg::QCNT_W-1:0] q_count;

  ptrf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .req_valid    (in_tvalid),
    .req_ready    (in_tready),
    .cmd          (in_tuser),
    .command_tag  (in_tdata[7:0]),
    .data_byte    (in_tdata[15:8]),
    .last_in_chunk(in_tlast),
    .read_index   (in_tdata[23:16]),
    .q_count      (q_count),
    .push         (push),
    .push_res     (push_res)
  );

  ptrf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_res (push_res),
    .q_count  (q_count),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (out_res)
  );

  assign out_tdata = {2'b00, out_res};

endmodule

[sim/prompt_terminated_response_framer_tb.sv]
// self-checking testbench for the prompt terminated response framer
module prompt_terminated_response_framer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS = 212;
  localparam int NUM_PHASES = 6;

  class reply_framer_scoreboard;
    bit [31:0]      tick_limit;
    bit             busy;
    bit [7:0]       tag;
    bit [7:0]       reply_mem [ptrf_pkg::BUFFER_DEPTH];
    int unsigned    reply_len;
    bit [31:0]      ticks;
    bit             prompt_seen;
    int unsigned    err_pos;
    bit             err_found;
    bit [7:0]       err_word [5];
    ptrf_pkg::res_t expected_q [$];
    int             errors;

    function new();
      tick_limit = ptrf_pkg::TIMEOUT_RESET;
      busy = 1'b0;
      tag = '0;
      reply_len = 0;
      ticks = '0;
      prompt_seen = 1'b0;
      err_pos = 0;
      err_found = 1'b0;
      err_word = '{8'h45, 8'h52, 8'h52, 8'h4F, 8'h52};
      errors = 0;
    endfunction

    function void set_timeout(bit [31:0] value);
      tick_limit = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // no border in the word, so a mismatch restarts only on its first letter
    function void track_error_word(bit [7:0] b);
      if (err_found) return;
      if (err_pos < ptrf_pkg::MATCH_LEN && b == err_word[err_pos]) err_pos++;
      else err_pos = (b == err_word[0]) ? 1 : 0;
      if (err_pos >= ptrf_pkg::MATCH_LEN) begin
        err_found = 1'b1;
        err_pos = 0;
      end
    endfunction

    function void note_request(logic [2:0] user, logic [23:0] data, logic last);
      logic [2:0]     code;
      bit [7:0]       b;
      bit [7:0]       ridx;
      ptrf_pkg::res_t r;
      code = user;
      b = data[15:8];
      ridx = data[23:16];
      r = '0;
      r.status = ptrf_pkg::ST_ACCEPTED;
      case (code)
        ptrf_pkg::CMD_BEGIN: begin
          if (busy) begin
            r.status = ptrf_pkg::ST_BUSY;
          end else begin
            busy = 1'b1;
            tag = data[7:0];
            reply_len = 0;
            ticks = '0;
            prompt_seen = 1'b0;
            err_pos = 0;
            err_found = 1'b0;
          end
        end
        ptrf_pkg::CMD_DATA: begin
          if (!busy) begin
            r.status = ptrf_pkg::ST_IDLE;
          end else begin
            if (reply_len < ptrf_pkg::BUFFER_DEPTH - 1) begin
              reply_mem[reply_len] = b;
              reply_len++;
              track_error_word(b);
            end else begin
              r.status = ptrf_pkg::ST_DROPPED;
            end
            if (b == ptrf_pkg::PROMPT_CHAR) prompt_seen = 1'b1;
            if (last) begin
              if (prompt_seen || err_found) begin
                busy = 1'b0;
                r.finished = 1'b1;
                r.finished_ok = 1'b1;
              end
              prompt_seen = 1'b0;
            end
          end
        end
        ptrf_pkg::CMD_TICK: begin
          if (!busy) r.status = ptrf_pkg::ST_IDLE;
          else if (ticks != 32'hFFFF_FFFF) ticks++;
        end
        ptrf_pkg::CMD_ABORT: begin
          if (!busy) begin
            r.status = ptrf_pkg::ST_IDLE;
          end else begin
            busy = 1'b0;
            prompt_seen = 1'b0;
            r.finished = 1'b1;
          end
        end
        ptrf_pkg::CMD_READ: begin
          if (ridx < reply_len) r.read_byte = reply_mem[ridx];
        end
        default: r.status = ptrf_pkg::ST_IDLE;
      endcase
      r.busy_res = busy;
      r.timed_out = busy && (ticks >= tick_limit);
      r.response_len = reply_len[7:0];
      r.tag_out = tag;
      expected_q.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] e, logic [31:0] a);
      if (a !== e) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, a);
      end
    endfunction

    function void check_result(logic [31:0] data);
      ptrf_pkg::res_t got;
      ptrf_pkg::res_t want;
      got = ptrf_pkg::res_t'(data[29:0]);
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected nothing actual %0h",
                 $time, data);
        return;
      end
      want = expected_q.pop_front();
      check_field("status", want.status, got.status);
      check_field("busy_res", want.busy_res, got.busy_res);
      check_field("timed_out", want.timed_out, got.timed_out);
      check_field("finished", want.finished, got.finished);
      check_field("finished_ok", want.finished_ok, got.finished_ok);
      check_field("response_len", want.response_len, got.response_len);
      check_field("tag_out", want.tag_out, got.tag_out);
      check_field("read_byte", want.read_byte, got.read_byte);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wen = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  reply_framer_scoreboard sb = new();

  int send_idle_pct = 10;
  int recv_idle_pct = 70;
  int sent = 0;
  int reply_no = 0;
  int stall_cycles = 0;

  bit [31:0] phase_timeouts [NUM_PHASES] = '{32'd3, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd12,
                                             32'd1000};

  prompt_terminated_response_framer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // requests are predicted and results checked in one place, in edge order
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_request(in_tuser, in_tdata, in_tlast);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [2:0] code, input logic [7:0] tag,
                              input logic [7:0] b, input logic last,
                              input logic [7:0] ridx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {ridx, b, tag};
    in_tuser <= code;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last);
    send_request(ptrf_pkg::CMD_DATA, 8'($urandom), b, last, 8'($urandom));
  endtask

  task automatic push_cmd(input logic [2:0] code);
    send_request(code, 8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
  endtask

  task automatic push_read();
    logic [7:0] ridx;
    ridx = $urandom_range(1) ? 8'($urandom) : 8'($urandom_range(0, 7));
    send_request(ptrf_pkg::CMD_READ, 8'($urandom), 8'($urandom), 1'($urandom), ridx);
  endtask

  // only while nothing is in flight
  task automatic write_timeout(input logic [31:0] value);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    sb.set_timeout(value);
  endtask

  function automatic logic [7:0] reply_char();
    case ($urandom_range(9))
      0:       return 8'h45;
      1:       return 8'h52;
      2:       return 8'h4F;
      default: return 8'($urandom);
    endcase
  endfunction

  // one command reply: begin, a few chunks, then a prompt, ERROR or abort
  task automatic run_reply();
    int         nchunks;
    int         len;
    int         end_kind;
    bit         long_reply;
    logic [7:0] b;
    case ($urandom_range(11))
      0: push_byte(8'($urandom), 1'($urandom));
      1: push_cmd(3'(ptrf_pkg::CMD_READ) + 3'($urandom_range(1, 3)));
      2: push_cmd(ptrf_pkg::CMD_TICK);
      3: push_cmd(ptrf_pkg::CMD_ABORT);
      default: ;
    endcase
    push_cmd(ptrf_pkg::CMD_BEGIN);
    if ($urandom_range(3) == 0) repeat ($urandom_range(0, 15)) push_cmd(ptrf_pkg::CMD_TICK);
    long_reply = (reply_no % 9 == 4);
    nchunks = $urandom_range(1, 3);
    end_kind = $urandom_range(0, 3);
    for (int c = 0; c < nchunks; c++) begin
      len = (long_reply && c == 0) ? $urandom_range(250, 262) : $urandom_range(1, 7);
      if (c == nchunks - 1 && end_kind == 2) begin
        foreach (sb.err_word[k]) push_byte(sb.err_word[k], 1'b0);
      end
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(9) == 0) push_cmd(ptrf_pkg::CMD_TICK);
        if ($urandom_range(11) == 0) push_read();
        if ($urandom_range(49) == 0) push_cmd(ptrf_pkg::CMD_BEGIN);
        b = reply_char();
        if (c == nchunks - 1) begin
          if (end_kind == 0 && i == len - 1) b = ptrf_pkg::PROMPT_CHAR;
          if (end_kind == 1 && i == len / 2) b = ptrf_pkg::PROMPT_CHAR;
        end
        push_byte(b, i == len - 1);
      end
    end
    if (end_kind == 3 || $urandom_range(9) == 0) push_cmd(ptrf_pkg::CMD_ABORT);
    if ($urandom_range(2) == 0) repeat ($urandom_range(1, 3)) push_read();
    reply_no++;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle behavior
    send_request(ptrf_pkg::CMD_READ, 8'h00, 8'h00, 1'b0, 8'h00);
    send_request(ptrf_pkg::CMD_DATA, 8'hFF, 8'hFF, 1'b1, 8'hFF);
    send_request(ptrf_pkg::CMD_TICK, 8'h00, 8'h00, 1'b0, 8'h00);
    send_request(ptrf_pkg::CMD_ABORT, 8'hFF, 8'hFF, 1'b1, 8'hFF);
    send_request(3'(ptrf_pkg::CMD_READ) + 3'd3, 8'hFF, 8'hFF, 1'b1, 8'hFF);
    send_request(3'(ptrf_pkg::CMD_READ) + 3'd1, 8'h00, 8'h00, 1'b0, 8'h00);
    // begin, rejected begin, chunk without prompt, prompt before chunk end
    send_request(ptrf_pkg::CMD_BEGIN, 8'hFF, 8'h00, 1'b0, 8'h00);
    send_request(ptrf_pkg::CMD_BEGIN, 8'h00, 8'hFF, 1'b1, 8'hFF);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_cmd(ptrf_pkg::CMD_TICK);
    push_byte(ptrf_pkg::PROMPT_CHAR, 1'b0);
    push_byte(8'h41, 1'b1);
    // reads after close, past the stored bytes too
    send_request(ptrf_pkg::CMD_READ, 8'h00, 8'h00, 1'b0, 8'd0);
    send_request(ptrf_pkg::CMD_READ, 8'h00, 8'h00, 1'b0, 8'd1);
    send_request(ptrf_pkg::CMD_READ, 8'h00, 8'h00, 1'b0, 8'd3);
    send_request(ptrf_pkg::CMD_READ, 8'h00, 8'h00, 1'b0, 8'd255);
    // closed by ERROR
    send_request(ptrf_pkg::CMD_BEGIN, 8'h5A, 8'h00, 1'b0, 8'h00);
    for (int k = 0; k < 5; k++) push_byte(sb.err_word[k], k == 4);
    // abort mid-chunk after a prompt
    send_request(ptrf_pkg::CMD_BEGIN, 8'hA5, 8'h00, 1'b0, 8'h00);
    push_byte(ptrf_pkg::PROMPT_CHAR, 1'b0);
    push_cmd(ptrf_pkg::CMD_ABORT);
    send_request(ptrf_pkg::CMD_READ, 8'h00, 8'h00, 1'b0, 8'd0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p / 2)
        0: begin
          send_idle_pct = 10;
          recv_idle_pct = 70;
        end
        1: begin
          send_idle_pct = 70;
          recv_idle_pct = 10;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_timeout(phase_timeouts[p]);
      while (sent < 27 + (p + 1) * PHASE_ITEMS) run_reply();
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
